/* design/idfq_pkg.sv */
package idfq_pkg;

  localparam int MAX_FRAME_DEF  = 4096;
  localparam int MAX_QUEUES_DEF = 32;

  localparam logic [15:0] TAG_A     = 16'h8100;
  localparam logic [15:0] TAG_B     = 16'h88a8;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [31:0] MIX_C1    = 32'h85ebca6b;
  localparam logic [31:0] MIX_C2    = 32'hc2b2ae35;
  localparam int          ETH_HDR   = 14;

  localparam logic [1:0] REG_ENCAP_ON = 2'd0;
  localparam logic [1:0] REG_ENCAP_TYPE = 2'd1;
  localparam logic [1:0] REG_TX_QUEUES = 2'd2;
  localparam logic [1:0] REG_FALLBACK = 2'd3;

  // Per-frame summary handed from the parser to the queue selector.
  typedef struct packed {
    logic        tun;
    logic [4:0]  base;
    logic [12:0] ilen;
    logic [31:0] daddr;
    logic        dvalid;
    logic        fvalid;
    logic [31:0] hash_in;
    logic [4:0]  fallback;
    logic [5:0]  nq;
  } frame_sum_t;

  // Result fields (was_tunneled lowest).
  typedef struct packed {
    logic [4:0]  queue_index;
    logic        flow_valid;
    logic        dest_valid;
    logic [31:0] dest_address;
    logic [12:0] frame_length_out;
    logic [4:0]  strip_length;
    logic        was_tunneled;
  } result_t;

endpackage

/* design/idfq_parser.sv */
module idfq_parser
  import idfq_pkg::*;
#(
  parameter int MAX_FRAME  = MAX_FRAME_DEF,
  parameter int MAX_QUEUES = MAX_QUEUES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       encap_on,
  input  logic [15:0] encap_type,
  input  logic [5:0] tx_queues,
  input  logic [4:0] fallback_queue,
  output logic       sum_valid,
  input  logic       sum_ready,
  output frame_sum_t sum
);

  localparam int PW = $clog2(MAX_FRAME + 1);

  logic [PW-1:0] pos;
  logic [15:0] outer_type, inner_type;
  logic [1:0]  tag_count;
  logic [4:0]  inner_base;
  logic        tunnel_seen;
  logic [3:0]  hdr_words;
  logic [7:0]  proto;
  logic [31:0] saddr, daddr;
  logic [15:0] sport, dport;

  logic          take;
  logic          active;
  logic [PW-1:0] len;
  logic [PW-1:0] r;
  logic [PW-1:0] t;
  logic          in_inner;
  logic [PW-1:0] p;
  logic [15:0]   ot_next;
  logic [1:0]    k;
  logic          cand;

  // Input ready waits on the summary holding register; byte position arithmetic
  assign in_ready = !sum_valid || sum_ready;
  assign take     = in_valid && in_ready;
  assign p        = pos;
  assign active   = pos < PW'(MAX_FRAME);
  assign len      = active ? pos + 1'b1 : pos;
  assign in_inner = p >= PW'(inner_base);
  assign r        = p - PW'(inner_base);
  assign t        = PW'(ETH_HDR) + PW'({hdr_words, 2'b00});

  always_comb begin
    cand = (p == PW'(13)) || (p == PW'(17)) || (p == PW'(21));
    k = (p == PW'(13)) ? 2'd0 : (p == PW'(17)) ? 2'd1 : 2'd2;
    if (cand || p == PW'(12) || p == PW'(16) || p == PW'(20))
      ot_next = {outer_type[7:0], data_byte};
    else
      ot_next = outer_type;
  end

  // Frame end evaluation
  frame_sum_t s;
  logic        tun, is_ip, fv, tcpudp, long_ip;
  logic [4:0]  base;
  logic [PW-1:0] ilen, need;
  logic [15:0] ps, pd;
  logic [3:0]  hw_f;
  logic [7:0]  pr_f;
  logic [31:0] da_f, sa_f;
  logic [15:0] it_f, sp_f, dp_f;
  logic        ts_f;
  logic [4:0]  ib_f;

  always_comb begin
    // include effects of the final byte
    hw_f = hdr_words; pr_f = proto; da_f = daddr; sa_f = saddr;
    it_f = inner_type; sp_f = sport; dp_f = dport; ts_f = tunnel_seen; ib_f = inner_base;
    if (active) begin
      if (cand && !tunnel_seen && tag_count == k &&
          encap_on && encap_type != 16'd0 && ot_next == encap_type) begin
        ts_f = 1'b1;
        ib_f = 5'(ETH_HDR + 4) + {1'b0, k, 2'b00};
      end
      if (in_inner) begin
        if (r == PW'(12) || r == PW'(13)) it_f = {inner_type[7:0], data_byte};
        if (r == PW'(23)) pr_f = data_byte;
        if (r == PW'(29)) sa_f[31:24] = data_byte;
        if (r == PW'(33)) da_f[31:24] = data_byte;
        if (r == t + PW'(1)) sp_f[7:0] = data_byte;
        if (r == t + PW'(3)) dp_f[7:0] = data_byte;
      end
    end
    tun   = ts_f && (len >= PW'(ib_f) + PW'(ETH_HDR));
    base  = tun ? ib_f : 5'd0;
    ilen  = len - PW'(base);
    is_ip = (tun || ib_f == 5'd0) && it_f == TYPE_IPV4;
    long_ip = is_ip && ilen >= PW'(ETH_HDR + 20);
    fv    = long_ip && hw_f >= 4'd5;
    tcpudp = pr_f == PROTO_TCP || pr_f == PROTO_UDP;
    need  = PW'(ETH_HDR) + PW'({hw_f, 2'b00}) + ((pr_f == PROTO_TCP) ? PW'(20) : PW'(8));
    ps = 16'd0; pd = 16'd0;
    if (fv && tcpudp) begin
      if (ilen < need) fv = 1'b0;
      else begin ps = sp_f; pd = dp_f; end
    end
    s.tun      = tun;
    s.base     = base;
    s.ilen     = 13'(ilen);
    s.daddr    = long_ip ? da_f : 32'd0;
    s.dvalid   = long_ip && da_f != 32'd0;
    s.fvalid   = fv;
    s.hash_in  = sa_f ^ da_f ^ {ps, pd} ^ {24'd0, pr_f};
    s.fallback = fallback_queue;
    if (tx_queues == 6'd0) s.nq = 6'd1;
    else if (tx_queues > 6'(MAX_QUEUES)) s.nq = 6'(MAX_QUEUES);
    else s.nq = tx_queues;
  end

  // Per-byte field capture and the summary output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else begin
      if (sum_valid && sum_ready) sum_valid <= 1'b0;
      if (take && last_byte) sum_valid <= 1'b1;
    end
    if (take && last_byte) sum <= s;
    if (rst || (take && last_byte)) begin
      pos <= '0; outer_type <= '0; tag_count <= '0; inner_base <= '0;
      tunnel_seen <= 1'b0; inner_type <= '0; hdr_words <= '0; proto <= '0;
      saddr <= '0; daddr <= '0; sport <= '0; dport <= '0;
    end else if (take && active) begin
      pos <= pos + 1'b1;
      outer_type <= ot_next;
      if (cand && !tunnel_seen && tag_count == k) begin
        if (encap_on && encap_type != 16'd0 && ot_next == encap_type) begin
          tunnel_seen <= 1'b1;
          inner_base  <= 5'(ETH_HDR + 4) + {1'b0, k, 2'b00};
        end else if (ot_next == TAG_A || ot_next == TAG_B) begin
          tag_count <= k + 2'd1;
        end
      end
      if (in_inner) begin
        if (r == PW'(12) || r == PW'(13)) inner_type <= {inner_type[7:0], data_byte};
        if (r == PW'(23)) proto <= data_byte;
        if (r == PW'(26)) saddr[7:0]   <= data_byte;
        if (r == PW'(27)) saddr[15:8]  <= data_byte;
        if (r == PW'(28)) saddr[23:16] <= data_byte;
        if (r == PW'(29)) saddr[31:24] <= data_byte;
        if (r == PW'(30)) daddr[7:0]   <= data_byte;
        if (r == PW'(31)) daddr[15:8]  <= data_byte;
        if (r == PW'(32)) daddr[23:16] <= data_byte;
        if (r == PW'(33)) daddr[31:24] <= data_byte;
        if (r == t)           sport <= {data_byte, 8'd0};
        if (r == t + PW'(1))  sport <= {sport[15:8], data_byte};
        if (r == t + PW'(2))  dport <= {data_byte, 8'd0};
        if (r == t + PW'(3))  dport <= {dport[15:8], data_byte};
        if (r == PW'(14))     hdr_words <= data_byte[3:0];
      end
    end
  end

endmodule

/* design/idfq_fifo.sv */
module idfq_fifo
  import idfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  frame_sum_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output frame_sum_t rd_data
);

  // Two-entry queue between parser and queue selector
  frame_sum_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      cnt <= cnt + 2'((wr_valid && wr_ready)) - 2'((rd_valid && rd_ready));
    end
  end

endmodule

/* design/idfq_selector.sv */
module idfq_selector
  import idfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sum_valid,
  output logic       sum_ready,
  input  frame_sum_t sum,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  frame_sum_t  cur;
  logic [31:0] h;
  logic [5:0]  rem;
  logic [4:0]  step;

  assign sum_ready = state == S_IDLE;
  assign res_valid = state == S_OUT;

  // Hash mix (fallback queue for non-flow frames), then restoring remainder one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (sum_valid) begin
          cur   <= sum;
          h     <= sum.hash_in ^ (sum.hash_in >> 16);
          state <= S_MUL1;
        end
        S_MUL1: begin
          h     <= (h * MIX_C1) ^ ((h * MIX_C1) >> 13);
          state <= S_MUL2;
        end
        S_MUL2: begin
          h <= cur.fvalid ? ((h * MIX_C2) ^ ((h * MIX_C2) >> 16))
                          : {27'd0, cur.fallback};
          rem   <= 6'd0;
          step  <= 5'd31;
          state <= S_MOD;
        end
        S_MOD: begin
          if ({rem[4:0], h[step]} >= cur.nq)
            rem <= {rem[4:0], h[step]} - cur.nq;
          else
            rem <= {rem[4:0], h[step]};
          if (step == 5'd0) state <= S_OUT;
          step <= step - 5'd1;
        end
        S_OUT: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.was_tunneled     = cur.tun;
    res.strip_length     = cur.base;
    res.frame_length_out = cur.ilen;
    res.dest_address     = cur.daddr;
    res.dest_valid       = cur.dvalid;
    res.flow_valid       = cur.fvalid;
    res.queue_index      = rem[4:0];
  end

endmodule

/* design/ingress_decap_flow_queue_classifier_unit.sv */
// Channel | fields (low bit first)                                   | handshake
// s_axis  | tdata: data_byte[7:0]; tlast: last_byte                   | tvalid/tready
// m_axis  | tdata: was_tunneled, strip_length, frame_length_out,      | tvalid/tready
//         |   dest_address, dest_valid, flow_valid, queue_index       |
// cfg     | cfg_we, cfg_index, cfg_data                               | write only
// The parser takes one byte per cycle unless its summary register is full; each
// summary passes a two-entry queue to the selector, which takes one frame at a time
// for the hash multiplies and a bit-serial remainder. Frames of 36+ bytes stream at
// full rate unless m_axis stalls. rst is synchronous and clears all control state.
module ingress_decap_flow_queue_classifier_unit
  import idfq_pkg::*;
#(
  parameter int MAX_FRAME  = MAX_FRAME_DEF,
  parameter int MAX_QUEUES = MAX_QUEUES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // was_tunneled, strip_length, frame_length_out,
                                      // dest_address, dest_valid, flow_valid, queue_index
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        encap_on;
  logic [15:0] encap_type;
  logic [5:0]  tx_queues;
  logic [4:0]  fallback_queue;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      encap_on <= 1'b0; encap_type <= 16'd0; tx_queues <= 6'd1; fallback_queue <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENCAP_ON:   encap_on <= cfg_data[0];
        REG_ENCAP_TYPE: encap_type <= cfg_data;
        REG_TX_QUEUES:  tx_queues <= cfg_data[5:0];
        REG_FALLBACK:   fallback_queue <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  frame_sum_t psum, qsum;
  logic       pv, pr, qv, qr;
  result_t    res;

  idfq_parser #(.MAX_FRAME(MAX_FRAME), .MAX_QUEUES(MAX_QUEUES)) u_parser (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata), .last_byte(s_axis_tlast),
    .encap_on, .encap_type, .tx_queues, .fallback_queue,
    .sum_valid(pv), .sum_ready(pr), .sum(psum)
  );

  idfq_fifo u_fifo (
    .clk, .rst,
    .wr_valid(pv), .wr_ready(pr), .wr_data(psum),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qsum)
  );

  idfq_selector u_sel (
    .clk, .rst,
    .sum_valid(qv), .sum_ready(qr), .sum(qsum),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {6'd0, res};

endmodule

/* tb/tb_ingress_decap_flow_queue_classifier_unit.sv */
module tb_ingress_decap_flow_queue_classifier_unit;
  import idfq_pkg::*;

  localparam int MAX_FRAME  = MAX_FRAME_DEF;
  localparam int MAX_QUEUES = MAX_QUEUES_DEF;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // was_tunneled, strip_length, frame_length_out,
                               // dest_address, dest_valid, flow_valid, queue_index
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  ingress_decap_flow_queue_classifier_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers
  logic        sh_encap_on;
  logic [15:0] sh_encap_type;
  logic [5:0]  sh_tx_queues;
  logic [4:0]  sh_fallback;

  // Per-frame parse state of the classifier model
  int unsigned pos, outer_tw, tag_cnt, ibase, tun_seen, inner_tw, hdr_words;
  int unsigned proto_b, src_addr, dst_word, sport_w, dport_w;

  result_t     classifications[$];
  logic [7:0]  frame[$];
  int          errors;
  bit          tx_idle;
  bit          rx_idle;
  int          hold_req;

  // Clock and run limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] flow_hash(logic [31:0] sa, logic [31:0] da,
                                            logic [15:0] sp, logic [15:0] dp,
                                            logic [7:0] pr);
    logic [31:0] h;
    h = sa ^ da ^ {sp, dp} ^ {24'd0, pr};
    h = h ^ (h >> 16);
    h = h * MIX_C1;
    h = h ^ (h >> 13);
    h = h * MIX_C2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic void clear_parse();
    pos = 0; outer_tw = 0; tag_cnt = 0; ibase = 0; tun_seen = 0; inner_tw = 0;
    hdr_words = 0; proto_b = 0; src_addr = 0; dst_word = 0; sport_w = 0;
    dport_w = 0;
  endfunction

  // Outer header: VLAN tags and tunnel ethertype
  function automatic void outer_step(int unsigned p, int unsigned b);
    int unsigned k;
    if (p == 12 || p == 13 || p == 16 || p == 17 || p == 20 || p == 21)
      outer_tw = ((outer_tw << 8) | b) & 16'hffff;
    if (p != 13 && p != 17 && p != 21) return;
    k = (p - 13) / 4;
    if (tun_seen != 0 || tag_cnt != k) return;
    if (sh_encap_on && sh_encap_type != 0 && outer_tw == sh_encap_type) begin
      tun_seen = 1;
      ibase = ETH_HDR + 4 * k + 4;
    end else if (outer_tw == TAG_A || outer_tw == TAG_B) begin
      tag_cnt = (k + 1) & 3;
    end
  endfunction

  // Inner frame: ethertype, IPv4 header and L4 ports
  function automatic void inner_step(int unsigned p, int unsigned b);
    int unsigned r, t;
    if (p < ibase) return;
    r = p - ibase;
    t = ETH_HDR + 4 * hdr_words;
    if (r == 12 || r == 13) inner_tw = ((inner_tw << 8) | b) & 16'hffff;
    if (r == 23) proto_b = b;
    if (r >= 26 && r <= 29) src_addr |= b << (8 * (r - 26));
    if (r >= 30 && r <= 33) dst_word |= b << (8 * (r - 30));
    if (r == t) sport_w = b << 8;
    if (r == t + 1) sport_w = (sport_w & 16'hff00) | b;
    if (r == t + 2) dport_w = b << 8;
    if (r == t + 3) dport_w = (dport_w & 16'hff00) | b;
    if (r == 14) hdr_words = b & 4'hf;
  endfunction

  // Model one accepted byte; on the last byte queue the frame's classification
  function automatic void classify_byte(logic [7:0] b, logic last);
    int unsigned len, base, ilen, nq, need, ps, pd;
    bit tun, is_ip, fvalid;
    logic [31:0] daddr;
    result_t res;
    if (pos < MAX_FRAME) begin
      outer_step(pos, b);
      inner_step(pos, b);
      pos++;
    end
    if (!last) return;
    len = pos;
    tun = tun_seen != 0 && len >= ibase + ETH_HDR;
    base = tun ? ibase : 0;
    ilen = len - base;
    // without a tunnel the outer frame is the inner frame
    is_ip = tun ? (inner_tw == TYPE_IPV4) : (ibase == 0 && inner_tw == TYPE_IPV4);
    daddr = (is_ip && ilen >= ETH_HDR + 20) ? dst_word : 32'd0;
    fvalid = is_ip && ilen >= ETH_HDR + 20 && hdr_words >= 5;
    ps = 0; pd = 0;
    if (fvalid && (proto_b == PROTO_TCP || proto_b == PROTO_UDP)) begin
      need = ETH_HDR + 4 * hdr_words + (proto_b == PROTO_TCP ? 20 : 8);
      if (ilen < need) fvalid = 0;
      else begin
        ps = sport_w; pd = dport_w;
      end
    end
    nq = sh_tx_queues;
    if (nq == 0) nq = 1;
    if (nq > MAX_QUEUES) nq = MAX_QUEUES;
    res.was_tunneled     = tun;
    res.strip_length     = base[4:0];
    res.frame_length_out = ilen[12:0];
    res.dest_address     = daddr;
    res.dest_valid       = daddr != 0;
    res.flow_valid       = fvalid;
    if (fvalid)
      res.queue_index = 5'(flow_hash(src_addr, dst_word, ps[15:0], pd[15:0], proto_b[7:0]) % nq);
    else
      res.queue_index = 5'(sh_fallback % nq);
    classifications.push_back(res);
    clear_parse();
  endfunction

  // Result side: random stalls, long hold on request, field checks
  int rx_wait;
  int hold_seen;
  int hold_cnt;
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0; hold_seen = 0; hold_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (classifications.size() == 0) begin
          $error("unexpected result transfer %h", m_axis_tdata);
          errors++;
        end else begin
          want = classifications.pop_front();
          if (got.was_tunneled !== want.was_tunneled) begin
            $error("was_tunneled exp %0d got %0d", want.was_tunneled, got.was_tunneled);
            errors++;
          end
          if (got.strip_length !== want.strip_length) begin
            $error("strip_length exp %0d got %0d", want.strip_length, got.strip_length);
            errors++;
          end
          if (got.frame_length_out !== want.frame_length_out) begin
            $error("frame_length_out exp %0d got %0d", want.frame_length_out,
                   got.frame_length_out);
            errors++;
          end
          if (got.dest_address !== want.dest_address) begin
            $error("dest_address exp %h got %h", want.dest_address, got.dest_address);
            errors++;
          end
          if (got.dest_valid !== want.dest_valid) begin
            $error("dest_valid exp %0d got %0d", want.dest_valid, got.dest_valid);
            errors++;
          end
          if (got.flow_valid !== want.flow_valid) begin
            $error("flow_valid exp %0d got %0d", want.flow_valid, got.flow_valid);
            errors++;
          end
          if (got.queue_index !== want.queue_index) begin
            $error("queue_index exp %0d got %0d", want.queue_index, got.queue_index);
            errors++;
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, 13) : 0;
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // One byte transfer on the input side
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    classify_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (classifications.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ENCAP_ON:   sh_encap_on   = val[0];
      REG_ENCAP_TYPE: sh_encap_type = val;
      REG_TX_QUEUES:  sh_tx_queues  = val[5:0];
      default:        sh_fallback   = val[4:0];
    endcase
  endtask

  task automatic set_config(logic on, logic [15:0] etype, logic [5:0] nq, logic [4:0] fb);
    wait_idle();
    write_reg(REG_ENCAP_ON, {15'd0, on});
    write_reg(REG_ENCAP_TYPE, etype);
    write_reg(REG_TX_QUEUES, {10'd0, nq});
    write_reg(REG_FALLBACK, {11'd0, fb});
  endtask

  // Frame image: MACs, tags, optional tunnel, inner MACs, IPv4, L4, payload
  task automatic build_frame(bit tunnel, int ntags, bit ipv4, int ihl, logic [7:0] proto,
                             logic [31:0] dst, int extra, int cut);
    logic [15:0] w;
    frame.delete();
    repeat (12) frame.push_back(8'($urandom));
    repeat (ntags) begin
      w = $urandom_range(0, 1) ? TAG_A : TAG_B;
      frame.push_back(w[15:8]); frame.push_back(w[7:0]);
      repeat (2) frame.push_back(8'($urandom));
    end
    if (tunnel) begin
      frame.push_back(sh_encap_type[15:8]); frame.push_back(sh_encap_type[7:0]);
      repeat (16) frame.push_back(8'($urandom));
    end
    w = ipv4 ? TYPE_IPV4 : 16'($urandom);
    frame.push_back(w[15:8]); frame.push_back(w[7:0]);
    frame.push_back({4'h4, 4'(ihl)});
    repeat (8) frame.push_back(8'($urandom));
    frame.push_back(proto);
    repeat (6) frame.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) frame.push_back(dst[8*i +: 8]);
    if (ihl > 5) repeat ((ihl - 5) * 4) frame.push_back(8'($urandom));
    repeat (20 + extra) frame.push_back(8'($urandom));
    if (cut > 0) while (frame.size() > cut) void'(frame.pop_back());
  endtask

  task automatic random_frame();
    int sel, ntags, ihl;
    logic [7:0] proto;
    logic [31:0] dst;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      // noise frame
      frame.delete();
      repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
    end else begin
      ntags = $urandom_range(0, 9);
      ntags = ntags < 5 ? 0 : ntags < 8 ? 1 : ntags < 9 ? 2 : 3;
      ihl = $urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : 5;
      sel = $urandom_range(0, 3);
      proto = sel == 0 ? 8'($urandom) : sel == 1 ? PROTO_UDP : PROTO_TCP;
      dst = $urandom_range(0, 9) == 0 ? 32'd0 : $urandom;
      build_frame($urandom_range(0, 3) != 0, ntags, $urandom_range(0, 7) != 0, ihl,
                  proto, dst, $urandom_range(0, 20),
                  $urandom_range(0, 4) == 0 ? $urandom_range(1, 80) : 0);
    end
    send_frame();
  endtask

  // Corner frames with and without tunneling
  task automatic test_directed();
    tx_idle = 1; rx_idle = 1;
    frame = '{8'hff};
    send_frame();
    build_frame(0, 0, 1, 5, PROTO_TCP, 32'hffffffff, 0, 0);
    send_frame();
    set_config(1, 16'h88b5, 6'd32, 5'd31);
    for (int t = 0; t <= 3; t++) begin
      build_frame(1, t, 1, 5, PROTO_UDP, $urandom, 0, 0);
      send_frame();
    end
    build_frame(1, 0, 1, 5, PROTO_TCP, 32'd0, 0, 0);        // zero destination: dest_valid low
    send_frame();
    build_frame(1, 1, 1, 5, PROTO_TCP, $urandom, 0, 28);    // short tunnel frame
    send_frame();
    build_frame(1, 0, 1, 3, PROTO_TCP, $urandom, 0, 0);     // header below 5 words
    send_frame();
    build_frame(1, 2, 1, 15, 8'd1, $urandom, 0, 0);         // other protocol, options
    send_frame();
    build_frame(1, 0, 1, 5, PROTO_TCP, $urandom, 0, 50);    // ports cut off
    send_frame();
    frame.delete();
    repeat (30) frame.push_back(8'h00);
    send_frame();
  endtask

  task automatic test_random_configs();
    int bytes, frames;
    logic [15:0] types[4];
    logic [5:0]  nqs[6];
    types = '{16'h0000, 16'hffff, TAG_A, 16'h88b5};
    nqs = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd7, 6'd5};
    bytes = 0; frames = 0;
    for (int ph = 0; bytes < 600 || frames < 8; ph++) begin
      set_config($urandom_range(0, 4) != 0,
                 ph % 3 == 0 ? types[$urandom_range(0, 3)] : 16'($urandom),
                 $urandom_range(0, 1) ? nqs[$urandom_range(0, 5)] : 6'($urandom),
                 5'($urandom));
      tx_idle = ph % 4 != 1; rx_idle = ph % 4 != 2;
      repeat (4) begin
        random_frame();
        bytes += frame.size();
        frames++;
      end
    end
  endtask

  // Receiver holds off while frames keep coming, then the sender drains
  task automatic test_backpressure();
    set_config(1, 16'h88b5, 6'd32, 5'd3);
    tx_idle = 0; rx_idle = 1;
    hold_req++;
    repeat (8) random_frame();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (classifications.size() != 0) @(posedge clk);
    tx_idle = 1;
    repeat (3) random_frame();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; hold_req = 0; tx_idle = 1; rx_idle = 1;
    sh_encap_on = 0; sh_encap_type = 0; sh_tx_queues = 1; sh_fallback = 0;
    clear_parse();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_configs();
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (classifications.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
